// ----- rtl/assert_macros.svh -----
// Assertion helpers; expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mdioc45_pkg.sv -----
package mdioc45_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	localparam logic [15:0] OP_WRITE    = 16'h1000;
	localparam logic [15:0] OP_READ     = 16'h3000;
	localparam logic [1:0]  TA_BITS     = 2'b10;
	localparam logic [15:0] READ_FILL   = 16'hffff;
	localparam logic [6:0]  FRAME_BITS  = 7'd32;
	localparam logic [2:0]  PRE_MIN     = 3'd1;
	localparam logic [2:0]  PRE_MAX     = 3'd4;
	localparam logic [2:0]  PRE_RESET   = 3'd4;

	typedef struct packed {
		cmd_t        command;
		logic [4:0]  port_addr;
		logic [4:0]  mmd_id;
		logic [15:0] reg_addr;
		logic [15:0] write_value;
		logic        mdio_in;
	} req_item_t;

	typedef struct packed {
		logic        mdio_out;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_data;
	} rsp_item_t;

	function automatic logic [15:0] header_bits(logic [4:0] phy, logic [4:0] dev);
		return {4'b0000, phy, dev, TA_BITS};
	endfunction

endpackage

// ----- rtl/mdioc45_if.sv -----
interface mdioc45_req_if;
	logic                 valid;
	logic                 ready;
	mdioc45_pkg::cmd_t    command;
	logic [4:0]           port_addr;
	logic [4:0]           mmd_id;
	logic [15:0]          reg_addr;
	logic [15:0]          write_value;
	logic                 mdio_in;

	modport source (output valid, command, port_addr, mmd_id, reg_addr, write_value,
		mdio_in, input ready);
	modport sink (input valid, command, port_addr, mmd_id, reg_addr, write_value,
		mdio_in, output ready);
endinterface

interface mdioc45_rsp_if;
	logic        valid;
	logic        ready;
	logic        mdio_out;
	logic        busy_res;
	logic        done_res;
	logic [15:0] read_data;

	modport source (output valid, mdio_out, busy_res, done_res, read_data, input ready);
	modport sink (input valid, mdio_out, busy_res, done_res, read_data, output ready);
endinterface

interface mdioc45_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/mdioc45_engine.sv -----
module mdioc45_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  mdioc45_pkg::req_item_t item,
	input  logic [2:0]             preamble_bytes,
	output mdioc45_pkg::rsp_item_t res
);
	import mdioc45_pkg::*;
	`include "assert_macros.svh"

	logic [31:0] address_word_q, address_word_d;
	logic [31:0] data_word_q, data_word_d;
	logic [6:0]  bit_pos_q, bit_pos_d;
	logic        second_q, second_d;
	logic        active_q, active_d;
	logic [15:0] capture_q, capture_d;

	logic [2:0]  pre_bytes;
	logic [5:0]  pre_bits;
	logic [6:0]  frame_len;
	logic [4:0]  offset;
	logic [4:0]  bit_idx;
	logic [6:0]  pos_next;
	logic [31:0] word;
	logic [15:0] hdr;

	always_comb begin
		if (preamble_bytes < PRE_MIN) begin
			pre_bytes = PRE_MIN;
		end else if (preamble_bytes > PRE_MAX) begin
			pre_bytes = PRE_MAX;
		end else begin
			pre_bytes = preamble_bytes;
		end
		pre_bits  = {pre_bytes, 3'b000};
		frame_len = {1'b0, pre_bits} + FRAME_BITS;
		offset    = 5'(bit_pos_q - {1'b0, pre_bits});
		bit_idx   = 5'd31 - offset;
		pos_next  = bit_pos_q + 7'd1;
		word      = second_q ? data_word_q : address_word_q;
		hdr       = header_bits(item.port_addr, item.mmd_id);

		address_word_d = address_word_q;
		data_word_d    = data_word_q;
		bit_pos_d      = bit_pos_q;
		second_d       = second_q;
		active_d       = active_q;
		capture_d      = capture_q;
		res.mdio_out   = 1'b1;
		res.done_res   = 1'b0;

		if ((item.command == CMD_WRITE || item.command == CMD_READ) && !active_q) begin
			address_word_d = {hdr, item.reg_addr};
			if (item.command == CMD_WRITE) begin
				data_word_d = {OP_WRITE | hdr, item.write_value};
			end else begin
				data_word_d = {OP_READ | hdr, READ_FILL};
			end
			bit_pos_d = '0;
			second_d  = 1'b0;
			capture_d = '0;
			active_d  = 1'b1;
		end else if (item.command == CMD_TICK && active_q) begin
			if (bit_pos_q >= {1'b0, pre_bits} && bit_pos_q < frame_len) begin
				res.mdio_out = word[bit_idx];
			end
			capture_d = {capture_q[14:0], item.mdio_in};
			if (pos_next >= frame_len) begin
				bit_pos_d = '0;
				if (second_q) begin
					second_d     = 1'b0;
					active_d     = 1'b0;
					res.done_res = 1'b1;
				end else begin
					second_d = 1'b1;
				end
			end else begin
				bit_pos_d = pos_next;
			end
		end

		res.busy_res  = active_d;
		res.read_data = capture_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_word_q <= '0;
			data_word_q    <= '0;
			bit_pos_q      <= '0;
			second_q       <= 1'b0;
			active_q       <= 1'b0;
			capture_q      <= '0;
		end else if (fire) begin
			address_word_q <= address_word_d;
			data_word_q    <= data_word_d;
			bit_pos_q      <= bit_pos_d;
			second_q       <= second_d;
			active_q       <= active_d;
			capture_q      <= capture_d;
		end
	end

	`ASSERT_IMP(a_second_needs_active, second_q, active_q, "data frame flagged while idle")
	`ASSERT_IMP(a_pos_in_range, active_q, !bit_pos_q[6], "bit position beyond longest frame")
	`ASSERT_IMP(a_done_from_data_frame, fire && res.done_res, second_q && !res.busy_res,
		"done outside the data frame")

endmodule

// ----- rtl/mdio_clause45_frame_master.sv -----
// An accepted transfer is held in the input register, then presented from the result register.
// Throughput: one item per cycle; input register, single-pass logic, result register.
// Stalls on the result side hold the input register and stop the engine.
// Reset: idle, frame state and capture cleared, preamble_bytes set to 4.
module mdio_clause45_frame_master (
	input  logic        clk,
	input  logic        arst_n,
	mdioc45_req_if.sink   req,
	mdioc45_rsp_if.source rsp,
	mdioc45_cfg_if.sink   cfg
);
	import mdioc45_pkg::*;
	`include "assert_macros.svh"

	logic [2:0] preamble_q;
	logic       valid_s1;
	req_item_t  item_s1;
	logic       rsp_valid_q;
	rsp_item_t  rsp_q;
	rsp_item_t  res;
	logic       advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PRE_RESET;
		end else if (cfg.valid) begin
			preamble_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.command     <= req.command;
			item_s1.port_addr   <= req.port_addr;
			item_s1.mmd_id      <= req.mmd_id;
			item_s1.reg_addr    <= req.reg_addr;
			item_s1.write_value <= req.write_value;
			item_s1.mdio_in     <= req.mdio_in;
		end
	end

	mdioc45_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (advance),
		.item           (item_s1),
		.preamble_bytes (preamble_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp.ready) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.mdio_out  = rsp_q.mdio_out;
	assign rsp.busy_res  = rsp_q.busy_res;
	assign rsp.done_res  = rsp_q.done_res;
	assign rsp.read_data = rsp_q.read_data;

	`ASSERT_NXT(a_stalled_item_kept, valid_s1 && !advance, valid_s1, "stalled item dropped")
	`ASSERT_NXT(a_advance_fills_output, advance, rsp_valid_q, "result lost on advance")
	`ASSERT_IMP(a_done_not_busy, rsp_valid_q && rsp_q.done_res, !rsp_q.busy_res,
		"done with busy set")

endmodule
